### design/assert_macros.svh
// Assertion macros shared by the flow priority selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define FPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent implication on clk_i, disabled while rst_ni is low.
`define FPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/fps_pkg.sv
// Types and codes shared by the flow priority selector modules.
`default_nettype none

package fps_pkg;

  localparam logic [1:0] REQ_ARRIVE = 2'd0;
  localparam logic [1:0] REQ_SELECT = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_NO_FLOW = 2'd1;
  localparam logic [1:0] RES_NO_SEND = 2'd2;

  localparam int unsigned ADDR_SLOTS = 16;
  localparam logic [4:0]  FLOW_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    SLOT_CREATED = 2'd0,
    SLOT_ARRIVED = 2'd1,
    SLOT_SENDING = 2'd2,
    SLOT_DONE    = 2'd3
  } slot_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [7:0]  flow;
    logic [15:0] arrival;
    logic [15:0] transmit;
    logic [7:0]  prio;
    logic        busy;
    logic        found;
    logic        fin_done;
    logic [39:0] best_key;
    logic [7:0]  best_flow;
    logic [4:0]  done_cnt;
  } token_t;

endpackage

`default_nettype wire

### design/fps_req_if.sv
// Request channel: valid/ready handshake carrying one request beat.
`default_nettype none

interface fps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  slot;
  logic [7:0]  flow_number;
  logic [15:0] arrival_time;
  logic [15:0] transmit_time;
  logic [7:0]  priority_req;

  modport source (
    output valid, req_type, slot, flow_number, arrival_time, transmit_time, priority_req,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, flow_number, arrival_time, transmit_time, priority_req,
    output ready
  );
endinterface

`default_nettype wire

### design/fps_res_if.sv
// Result channel: valid/ready handshake carrying one result beat.
`default_nettype none

interface fps_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       grant_valid;
  logic [3:0] grant_slot;
  logic [7:0] grant_flow_number;
  logic [4:0] completed_count;
  logic       all_done;

  modport source (
    output valid, status, grant_valid, grant_slot, grant_flow_number, completed_count,
           all_done,
    input  ready
  );
  modport sink (
    input  valid, status, grant_valid, grant_slot, grant_flow_number, completed_count,
           all_done,
    output ready
  );
endinterface

`default_nettype wire

### design/fps_cell.sv
// One flow slot cell: holds the slot state and updates the passing request token.
`default_nettype none

module fps_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [4:0]      flow_count_i,
  input  wire logic            tok_vld_i,
  input  wire fps_pkg::token_t tok_i,
  input  wire logic [IW-1:0]   best_idx_i,
  input  wire logic            grant_en_i,
  input  wire logic [IW-1:0]   grant_idx_i,
  output logic                 tok_vld_o,
  output fps_pkg::token_t      tok_o,
  output logic [IW-1:0]        best_idx_o
);

  localparam bit         ADDRESSABLE = (INDEX < int'(fps_pkg::ADDR_SLOTS));
  localparam logic [3:0] SLOT_ID     = 4'(INDEX);
  localparam logic [IW-1:0] CELL_ID  = IW'(INDEX);

  fps_pkg::slot_state_e status_q, status_d, status_new;
  logic [7:0]  flow_q;
  logic [7:0]  prio_q;
  logic [15:0] arr_q;
  logic [15:0] tx_q;

  logic            hit_arrive, hit_finish, in_use, take;
  logic [39:0]     key;
  fps_pkg::token_t tok_d;
  logic [IW-1:0]   best_idx_d;
  logic            tok_vld_q;
  fps_pkg::token_t tok_q;
  logic [IW-1:0]   best_idx_q;

  assign in_use = (32'(INDEX) < 32'(flow_count_i));
  assign key    = {prio_q, arr_q, tx_q};

  assign hit_arrive = tok_vld_i && (tok_i.op == fps_pkg::REQ_ARRIVE) && ADDRESSABLE &&
                      (tok_i.slot == SLOT_ID);
  assign hit_finish = tok_vld_i && (tok_i.op == fps_pkg::REQ_FINISH) && !tok_i.fin_done &&
                      (status_q == fps_pkg::SLOT_SENDING);
  assign take = tok_vld_i && (tok_i.op == fps_pkg::REQ_SELECT) && in_use &&
                (status_q == fps_pkg::SLOT_ARRIVED) &&
                (!tok_i.found || (key < tok_i.best_key));

  always_comb begin
    status_new = status_q;
    if (hit_arrive) begin
      status_new = fps_pkg::SLOT_ARRIVED;
    end else if (hit_finish) begin
      status_new = fps_pkg::SLOT_DONE;
    end
    status_d = status_new;
    if (grant_en_i && (grant_idx_i == CELL_ID)) begin
      status_d = fps_pkg::SLOT_SENDING;
    end
  end

  always_comb begin
    tok_d          = tok_i;
    best_idx_d     = best_idx_i;
    tok_d.busy     = tok_i.busy || (status_q == fps_pkg::SLOT_SENDING);
    tok_d.fin_done = tok_i.fin_done || hit_finish;
    tok_d.done_cnt = tok_i.done_cnt +
                     5'(in_use && (status_new == fps_pkg::SLOT_DONE));
    if (take) begin
      tok_d.found     = 1'b1;
      tok_d.best_key  = key;
      tok_d.best_flow = flow_q;
      best_idx_d      = CELL_ID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= fps_pkg::SLOT_CREATED;
      tok_vld_q <= 1'b0;
    end else begin
      status_q  <= status_d;
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_arrive) begin
      flow_q <= tok_i.flow;
      prio_q <= tok_i.prio;
      arr_q  <= tok_i.arrival;
      tx_q   <= tok_i.transmit;
    end
    if (tok_vld_i) begin
      tok_q      <= tok_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign tok_vld_o  = tok_vld_q;
  assign tok_o      = tok_q;
  assign best_idx_o = best_idx_q;

endmodule

`default_nettype wire

### design/flow_priority_selector.sv
// Path: request register, then the SLOTS cells in order, then the result token register and
// the output register; one request at a time, and a result waits in S_WRAP while the output is full;
// the request token walks the cell chain one cell per cycle.
// The next request is taken while the previous result still waits in the output register.
// Reset: all slots created, flow_count 16, no result pending; slot contents are undefined.
`default_nettype none
`include "assert_macros.svh"

module flow_priority_selector #(
  parameter int SLOTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  fps_req_if.sink         req_i,
  fps_res_if.source       res_o
);

  localparam int IW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WRAP
  } state_e;

  state_e          state_q;
  logic [4:0]      flow_count_q;
  fps_pkg::token_t tok_q;
  logic            tok_vld_q;
  fps_pkg::token_t res_tok_q;
  logic [IW-1:0]   res_idx_q;

  logic       out_vld_q;
  logic [1:0] out_status_q;
  logic       out_gvalid_q;
  logic [3:0] out_gslot_q;
  logic [7:0] out_gflow_q;
  logic [4:0] out_count_q;
  logic       out_all_q;

  fps_pkg::token_t tok_chain [SLOTS+1];
  logic [IW-1:0]   idx_chain [SLOTS+1];
  logic [SLOTS:0]  vld_chain;

  logic       out_free, grant_ok, grant_en;
  logic [4:0] in_use_n;
  logic [1:0] res_status;

  assign tok_chain[0] = tok_q;
  assign idx_chain[0] = '0;
  assign vld_chain[0] = tok_vld_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    fps_cell #(
      .INDEX (g),
      .IW    (IW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .flow_count_i (flow_count_q),
      .tok_vld_i    (vld_chain[g]),
      .tok_i        (tok_chain[g]),
      .best_idx_i   (idx_chain[g]),
      .grant_en_i   (grant_en),
      .grant_idx_i  (res_idx_q),
      .tok_vld_o    (vld_chain[g+1]),
      .tok_o        (tok_chain[g+1]),
      .best_idx_o   (idx_chain[g+1])
    );
  end

  assign in_use_n = (32'(flow_count_q) < 32'(SLOTS)) ? flow_count_q : 5'(SLOTS);
  assign out_free = !out_vld_q || res_o.ready;
  assign grant_ok = (res_tok_q.op == fps_pkg::REQ_SELECT) && res_tok_q.found &&
                    !res_tok_q.busy;
  assign grant_en = (state_q == S_WRAP) && out_free && grant_ok;

  always_comb begin
    res_status = fps_pkg::RES_OK;
    if ((res_tok_q.op == fps_pkg::REQ_SELECT) && !grant_ok) begin
      res_status = fps_pkg::RES_NO_FLOW;
    end else if ((res_tok_q.op == fps_pkg::REQ_FINISH) && !res_tok_q.fin_done) begin
      res_status = fps_pkg::RES_NO_SEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      flow_count_q <= fps_pkg::FLOW_COUNT_RST;
      tok_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
      out_status_q <= fps_pkg::RES_OK;
      out_gvalid_q <= 1'b0;
      out_gslot_q  <= '0;
      out_gflow_q  <= '0;
      out_count_q  <= '0;
      out_all_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        flow_count_q <= cfg_wdata_i;
      end
      tok_vld_q <= (state_q == S_IDLE) && req_i.valid;
      if ((state_q == S_WRAP) && out_free) begin
        out_vld_q    <= 1'b1;
        out_status_q <= res_status;
        out_gvalid_q <= grant_ok;
        out_gslot_q  <= grant_ok ? 4'(res_idx_q) : 4'd0;
        out_gflow_q  <= grant_ok ? res_tok_q.best_flow : 8'd0;
        out_count_q  <= res_tok_q.done_cnt;
        out_all_q    <= (res_tok_q.done_cnt == in_use_n);
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (vld_chain[SLOTS]) begin
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && req_i.valid) begin
      tok_q.op        <= req_i.req_type;
      tok_q.slot      <= req_i.slot;
      tok_q.flow      <= req_i.flow_number;
      tok_q.arrival   <= req_i.arrival_time;
      tok_q.transmit  <= req_i.transmit_time;
      tok_q.prio      <= req_i.priority_req;
      tok_q.busy      <= 1'b0;
      tok_q.found     <= 1'b0;
      tok_q.fin_done  <= 1'b0;
      tok_q.best_key  <= '0;
      tok_q.best_flow <= '0;
      tok_q.done_cnt  <= '0;
    end
    if ((state_q == S_RUN) && vld_chain[SLOTS]) begin
      res_tok_q <= tok_chain[SLOTS];
      res_idx_q <= idx_chain[SLOTS];
    end
  end

  assign req_i.ready             = (state_q == S_IDLE);
  assign res_o.valid             = out_vld_q;
  assign res_o.status            = out_status_q;
  assign res_o.grant_valid       = out_gvalid_q;
  assign res_o.grant_slot        = out_gslot_q;
  assign res_o.grant_flow_number = out_gflow_q;
  assign res_o.completed_count   = out_count_q;
  assign res_o.all_done          = out_all_q;

  `FPS_ASSERT(a_one_token, $onehot0(vld_chain), "more than one request token in the chain")
  `FPS_ASSERT_IMPLY(a_grant_quiet, grant_en, vld_chain == '0,
                    "grant written while a token is in the chain")
  `FPS_ASSERT_IMPLY(a_grant_status, res_o.valid && res_o.grant_valid,
                    res_o.status == fps_pkg::RES_OK, "grant reported with a failure status")
  `FPS_ASSERT_IMPLY(a_token_idle, vld_chain[SLOTS], state_q == S_RUN,
                    "token left the chain outside the run state")

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for flow_priority_selector: directed table, then randomized traffic.
module testbench;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [7:0]  flow_number;
    logic [15:0] arrival_time;
    logic [15:0] transmit_time;
    logic [7:0]  priority_req;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic       grant_valid;
    logic [3:0] grant_slot;
    logic [7:0] grant_flow;
    logic [4:0] done_count;
    logic       all_done;
  } outcome_t;

  typedef struct {
    bit         is_cfg;
    logic [4:0] cfg_val;
    request_t   req;
    bit         typed;
    outcome_t   want;
  } step_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;

  fps_req_if req_if ();
  fps_res_if res_if ();

  flow_priority_selector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #1 clk_i = ~clk_i;

  fps_pkg::slot_state_e slot_st   [fps_pkg::ADDR_SLOTS];
  logic [7:0]           slot_flow [fps_pkg::ADDR_SLOTS];
  logic [7:0]           slot_prio [fps_pkg::ADDR_SLOTS];
  logic [15:0]          slot_arr  [fps_pkg::ADDR_SLOTS];
  logic [15:0]          slot_tx   [fps_pkg::ADDR_SLOTS];
  logic [4:0]           flow_cnt = fps_pkg::FLOW_COUNT_RST;

  outcome_t  pending_q [$];
  step_row_t plan [$];
  int        errors = 0;
  int        items_sent = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        rx_wait = 0;

  function automatic int in_use();
    return (flow_cnt < fps_pkg::ADDR_SLOTS) ? int'(flow_cnt) : int'(fps_pkg::ADDR_SLOTS);
  endfunction

  function automatic outcome_t schedule_step(request_t r);
    outcome_t o;
    int       n;
    int       best;
    int       i;
    bit       busy;
    bit       found;
    o = '0;
    n = in_use();
    best = 0;
    busy = 1'b0;
    found = 1'b0;
    unique case (r.req_type)
      fps_pkg::REQ_ARRIVE: begin
        slot_flow[r.slot] = r.flow_number;
        slot_arr[r.slot]  = r.arrival_time;
        slot_tx[r.slot]   = r.transmit_time;
        slot_prio[r.slot] = r.priority_req;
        slot_st[r.slot]   = fps_pkg::SLOT_ARRIVED;
      end
      fps_pkg::REQ_SELECT: begin
        for (i = 0; i < fps_pkg::ADDR_SLOTS; i++)
          if (slot_st[i] == fps_pkg::SLOT_SENDING) busy = 1'b1;
        if (!busy) begin
          for (i = 0; i < n; i++) begin
            if (slot_st[i] == fps_pkg::SLOT_ARRIVED && (!found ||
                {slot_prio[i], slot_arr[i], slot_tx[i]} <
                {slot_prio[best], slot_arr[best], slot_tx[best]})) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          slot_st[best] = fps_pkg::SLOT_SENDING;
          o.grant_valid = 1'b1;
          o.grant_slot = best[3:0];
          o.grant_flow = slot_flow[best];
        end else begin
          o.status = fps_pkg::RES_NO_FLOW;
        end
      end
      fps_pkg::REQ_FINISH: begin
        for (i = 0; i < fps_pkg::ADDR_SLOTS; i++) begin
          if (!found && slot_st[i] == fps_pkg::SLOT_SENDING) begin
            slot_st[i] = fps_pkg::SLOT_DONE;
            found = 1'b1;
          end
        end
        if (!found) o.status = fps_pkg::RES_NO_SEND;
      end
      default: begin
      end
    endcase
    for (i = 0; i < n; i++)
      if (slot_st[i] == fps_pkg::SLOT_DONE) o.done_count = o.done_count + 5'd1;
    o.all_done = (int'(o.done_count) == n);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t random_request(logic [1:0] op, logic [3:0] s);
    request_t r;
    r.req_type = op;
    r.slot = s;
    r.flow_number = 8'($urandom_range(0, 255));
    r.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) :
                                            8'($urandom_range(0, 255));
    r.arrival_time = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) :
                                            16'($urandom_range(0, 65535));
    r.transmit_time = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) :
                                             16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic step_row_t req_row(logic [1:0] op, logic [3:0] s, logic [7:0] f,
                                        logic [15:0] a, logic [15:0] t, logic [7:0] p);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.req = {op, s, f, a, t, p};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic step_row_t checked(step_row_t row, outcome_t w);
    row.typed = 1'b1;
    row.want = w;
    return row;
  endfunction

  function automatic step_row_t cfg_row(logic [4:0] v);
    step_row_t row;
    row = req_row(REQ_NONE, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0);
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  // Entered and left at a falling edge; valid stays high for back-to-back beats.
  task automatic offer(request_t r, bit typed, outcome_t want);
    outcome_t guess;
    req_if.req_type = r.req_type;
    req_if.slot = r.slot;
    req_if.flow_number = r.flow_number;
    req_if.arrival_time = r.arrival_time;
    req_if.transmit_time = r.transmit_time;
    req_if.priority_req = r.priority_req;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    guess = schedule_step(r);
    pending_q.push_back(typed ? want : guess);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pace(int g);
    if (g > 0) begin
      req_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_flow_count(logic [4:0] v);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    flow_cnt = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic noise_block(int count);
    int c;
    for (c = 0; c < count; c++) begin
      offer(random_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15))), 1'b0, '0);
      pace(pick_gap());
    end
  endtask

  // Fill some in-use slots, then serve them with select beats, most of them followed by a finish beat.
  task automatic play_round();
    int n;
    int k;
    int j;
    int pick;
    int tmp;
    int order [fps_pkg::ADDR_SLOTS];
    n = in_use();
    if (n == 0) begin
      noise_block(6);
      return;
    end
    for (j = 0; j < n; j++) order[j] = j;
    for (j = n - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    k = $urandom_range(0, 1) ? n : $urandom_range(1, n);
    for (j = 0; j < k; j++) begin
      offer(random_request(fps_pkg::REQ_ARRIVE, 4'(order[j])), 1'b0, '0);
      pace(pick_gap());
      if ($urandom_range(0, 9) == 0) begin
        offer(random_request(fps_pkg::REQ_ARRIVE, 4'($urandom_range(0, 15))), 1'b0, '0);
        pace(pick_gap());
      end
    end
    for (j = 0; j <= k; j++) begin
      offer(random_request(fps_pkg::REQ_SELECT, 4'($urandom_range(0, 15))), 1'b0, '0);
      pace(pick_gap());
      if ($urandom_range(0, 7) != 0) begin
        offer(random_request(fps_pkg::REQ_FINISH, 4'($urandom_range(0, 15))), 1'b0, '0);
        pace(pick_gap());
      end
    end
  endtask

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd31;
    if (r == 2) return 5'd1;
    if (r == 3) return 5'd16;
    return 5'($urandom_range(1, 16));
  endfunction

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_wait > 0) begin
        res_if.ready = 1'b0;
        rx_wait--;
      end else begin
        res_if.ready = 1'b1;
        rx_wait = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          errors++;
        end
        if (res_if.grant_valid !== want.grant_valid) begin
          $error("grant_valid: expected %0d, got %0d", want.grant_valid, res_if.grant_valid);
          errors++;
        end
        if (res_if.grant_slot !== want.grant_slot) begin
          $error("grant_slot: expected %0d, got %0d", want.grant_slot, res_if.grant_slot);
          errors++;
        end
        if (res_if.grant_flow_number !== want.grant_flow) begin
          $error("grant_flow_number: expected %0d, got %0d", want.grant_flow,
                 res_if.grant_flow_number);
          errors++;
        end
        if (res_if.completed_count !== want.done_count) begin
          $error("completed_count: expected %0d, got %0d", want.done_count,
                 res_if.completed_count);
          errors++;
        end
        if (res_if.all_done !== want.all_done) begin
          $error("all_done: expected %0d, got %0d", want.all_done, res_if.all_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int start;
    int phase;
    step_row_t row;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_NONE;
    req_if.slot = '0;
    req_if.flow_number = '0;
    req_if.arrival_time = '0;
    req_if.transmit_time = '0;
    req_if.priority_req = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (slot_st[i]) begin
      slot_st[i] = fps_pkg::SLOT_CREATED;
      slot_flow[i] = '0;
      slot_prio[i] = '0;
      slot_arr[i] = '0;
      slot_tx[i] = '0;
    end

    plan.push_back(checked(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_NO_FLOW, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(checked(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_NO_SEND, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(checked(req_row(REQ_NONE, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                           {fps_pkg::RES_OK, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(checked(req_row(fps_pkg::REQ_ARRIVE, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF,
                                   8'hFF),
                           {fps_pkg::RES_OK, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(checked(req_row(fps_pkg::REQ_ARRIVE, 4'd0, 8'h00, 16'h0000, 16'h0000,
                                   8'h00),
                           {fps_pkg::RES_OK, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(req_row(fps_pkg::REQ_ARRIVE, 4'd3, 8'hA5, 16'd0, 16'd1, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_ARRIVE, 4'd7, 8'h5A, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_ARRIVE, 4'd9, 8'h33, 16'd1, 16'd0, 8'd0));
    plan.push_back(checked(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_OK, 1'b1, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(checked(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_NO_FLOW, 1'b0, 4'd0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_ARRIVE, 4'd7, 8'h77, 16'h8000, 16'h0100, 8'h80));
    plan.push_back(req_row(fps_pkg::REQ_ARRIVE, 4'd0, 8'h11, 16'd5, 16'd5, 8'h01));
    plan.push_back(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(cfg_row(5'd1));
    plan.push_back(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(cfg_row(5'd0));
    plan.push_back(checked(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_NO_FLOW, 1'b0, 4'd0, 8'd0, 5'd0, 1'b1}));
    plan.push_back(checked(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0),
                           {fps_pkg::RES_NO_SEND, 1'b0, 4'd0, 8'd0, 5'd0, 1'b1}));
    plan.push_back(cfg_row(5'd31));
    plan.push_back(req_row(fps_pkg::REQ_SELECT, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(req_row(fps_pkg::REQ_FINISH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    plan.push_back(cfg_row(5'd16));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        drain();
        set_flow_count(row.cfg_val);
      end else begin
        offer(row.req, row.typed, row.want);
        pace(pick_gap());
      end
    end

    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (items_sent - start >= (phase + 1) * 270) begin
        phase++;
        drain();
        set_flow_count(pick_count());
        if (phase == 2) begin
          // The sender keeps offering while the result side is held off.
          hold_req = 1'b1;
          calm = 1'b1;
          noise_block(12);
          continue;
        end
      end
      if ($urandom_range(0, 9) < 7) play_round();
      else noise_block(10);
    end

    calm = 1'b0;
    drain();
    repeat (fps_pkg::ADDR_SLOTS + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/fps_pkg.sv
design/fps_req_if.sv
design/fps_res_if.sv
design/fps_cell.sv
design/flow_priority_selector.sv
bench/testbench.sv
